FILE: hw/rtl/dda_pkg.sv
// shared types, constants and month-length helpers for the date day offset block
`timescale 1ns / 1ps

package dda_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 16;
    localparam int STAT_W  = 2;

    // internal widths: year walks a little below 0 and above 16383
    localparam int YACC_W = 16;
    localparam int DACC_W = 17;
    localparam int REM_W  = 9;
    localparam int Q_W    = 6;
    localparam int RCP_W  = 13;
    localparam int PROD_W = YEAR_W + RCP_W;

    // stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // floor(y / 400) = (y * 5243) >> 21 for every 14-bit y
    localparam logic [RCP_W-1:0] RECIP_400   = 13'd5243;
    localparam int               RECIP_SHIFT = 21;
    localparam logic [8:0]       CYCLE_YEARS = 9'd400;
    localparam logic [REM_W-1:0] REM_LAST    = 9'd399;
    localparam logic [REM_W-1:0] REM_C100    = 9'd100;
    localparam logic [REM_W-1:0] REM_C200    = 9'd200;
    localparam logic [REM_W-1:0] REM_C300    = 9'd300;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic signed [YACC_W-1:0] YEAR_MIN = 16'sd1;
    localparam logic signed [YACC_W-1:0] YEAR_MAX = 16'sd9999;
    localparam logic [DAY_W-1:0]         DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]         DAY_LAST  = 5'd31;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_CHECK,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_q;
        logic calc_rem;
        logic check;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_in;
        logic walk_done;
    } t_dp_sts;

    // leap rule from year mod 400: divisible by 4 but not a plain century
    function automatic logic is_leap(input logic [REM_W-1:0] rem);
        is_leap = (rem[1:0] == 2'd0) && (rem != REM_C100) && (rem != REM_C200)
                  && (rem != REM_C300);
    endfunction

    // month length, zero for a month code that means nothing
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        days_in = len;
    endfunction

endpackage

FILE: hw/rtl/dda_ctrl.sv
// controller state machine for the date day offset block
`timescale 1ns / 1ps

module dda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dda_pkg::t_dp_sts i_sts,
    output dda_pkg::t_dp_cmd o_cmd
);

    dda_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dda_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            dda_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dda_pkg::S_MUL;
                end
            end
            dda_pkg::S_MUL: begin
                o_cmd.calc_q = 1'b1;
                n_state      = dda_pkg::S_REM;
            end
            dda_pkg::S_REM: begin
                o_cmd.calc_rem = 1'b1;
                n_state        = dda_pkg::S_CHECK;
            end
            dda_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.bad_in ? dda_pkg::S_DONE : dda_pkg::S_WALK;
            end
            dda_pkg::S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = dda_pkg::S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            dda_pkg::S_DONE: begin
                // output register free or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = dda_pkg::S_IDLE;
                end
            end
            default: n_state = dda_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == dda_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/dda_dp.sv
// datapath for the date day offset block: date registers, month stepper, output register
`timescale 1ns / 1ps

module dda_dp (
    input  logic                                   i_clk,
    input  logic [dda_pkg::YEAR_W-1:0]             i_in_year,
    input  logic [dda_pkg::MONTH_W-1:0]            i_in_month,
    input  logic [dda_pkg::DAY_W-1:0]              i_in_day,
    input  logic signed [dda_pkg::OFF_W-1:0]       i_offset_days,
    input  dda_pkg::t_dp_cmd                       i_cmd,
    output dda_pkg::t_dp_sts                       o_sts,
    output logic [dda_pkg::YEAR_W-1:0]             o_out_year,
    output logic [dda_pkg::MONTH_W-1:0]            o_out_month,
    output logic [dda_pkg::DAY_W-1:0]              o_out_day,
    output dda_pkg::t_status                       o_status
);

    logic signed [dda_pkg::YACC_W-1:0] r_year;
    logic [dda_pkg::MONTH_W-1:0]       r_month;
    logic signed [dda_pkg::DACC_W-1:0] r_day;
    logic signed [dda_pkg::OFF_W-1:0]  r_off;
    logic [dda_pkg::Q_W-1:0]           r_q;
    logic [dda_pkg::REM_W-1:0]         r_rem;
    dda_pkg::t_status                  r_status;

    logic [dda_pkg::YEAR_W-1:0]  r_out_year;
    logic [dda_pkg::MONTH_W-1:0] r_out_month;
    logic [dda_pkg::DAY_W-1:0]   r_out_day;
    dda_pkg::t_status            r_out_status;

    logic [dda_pkg::PROD_W-1:0]        prod;
    logic [dda_pkg::YEAR_W-1:0]        q_times;
    logic                              leap;
    logic [dda_pkg::MONTH_W-1:0]       month_prev;
    logic signed [dda_pkg::DACC_W-1:0] dim_cur;
    logic signed [dda_pkg::DACC_W-1:0] dim_prev;
    logic                              fwd;
    logic                              bwd;
    logic                              month_ok;

    // year mod 400 via reciprocal multiply
    assign prod    = r_year[dda_pkg::YEAR_W-1:0] * dda_pkg::RECIP_400;
    assign q_times = dda_pkg::YEAR_W'(r_q) * dda_pkg::YEAR_W'(dda_pkg::CYCLE_YEARS);

    assign leap       = dda_pkg::is_leap(r_rem);
    assign month_prev = (r_month == dda_pkg::MONTH_JAN) ? dda_pkg::MONTH_DEC
                                                        : r_month - 4'd1;
    assign dim_cur  = $signed({12'd0, dda_pkg::days_in(r_month, leap)});
    assign dim_prev = $signed({12'd0, dda_pkg::days_in(month_prev, leap)});

    assign fwd      = (r_day > dim_cur);
    assign bwd      = (r_day < 17'sd1);
    assign month_ok = (r_month >= dda_pkg::MONTH_JAN) && (r_month <= dda_pkg::MONTH_DEC);

    assign o_sts.bad_in    = !month_ok || fwd || bwd;
    assign o_sts.walk_done = !fwd && !bwd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year   <= $signed({2'b00, i_in_year});
            r_month  <= i_in_month;
            r_day    <= $signed({12'd0, i_in_day});
            r_off    <= i_offset_days;
            r_status <= dda_pkg::ST_OK;
        end
        if (i_cmd.calc_q) begin
            r_q <= prod[dda_pkg::RECIP_SHIFT +: dda_pkg::Q_W];
        end
        if (i_cmd.calc_rem) begin
            r_rem <= dda_pkg::REM_W'(r_year[dda_pkg::YEAR_W-1:0] - q_times);
        end
        if (i_cmd.check) begin
            if (o_sts.bad_in) begin
                r_status <= dda_pkg::ST_BAD_DATE;
            end else begin
                r_day <= r_day + dda_pkg::DACC_W'(r_off);
            end
        end
        if (i_cmd.step) begin
            if (fwd) begin
                r_day <= r_day - dim_cur;
                if (r_month == dda_pkg::MONTH_DEC) begin
                    r_month <= dda_pkg::MONTH_JAN;
                    r_year  <= r_year + 16'sd1;
                    r_rem   <= (r_rem == dda_pkg::REM_LAST) ? '0 : r_rem + 9'd1;
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else if (bwd) begin
                // borrow the length of the month before, december when wrapping
                r_day   <= r_day + dim_prev;
                r_month <= month_prev;
                if (r_month == dda_pkg::MONTH_JAN) begin
                    r_year <= r_year - 16'sd1;
                    r_rem  <= (r_rem == '0) ? dda_pkg::REM_LAST : r_rem - 9'd1;
                end
            end
        end
        if (i_cmd.out_load) begin
            if (r_status == dda_pkg::ST_BAD_DATE) begin
                r_out_year   <= r_year[dda_pkg::YEAR_W-1:0];
                r_out_month  <= r_month;
                r_out_day    <= r_day[dda_pkg::DAY_W-1:0];
                r_out_status <= dda_pkg::ST_BAD_DATE;
            end else if (r_year < dda_pkg::YEAR_MIN) begin
                r_out_year   <= dda_pkg::YEAR_W'(dda_pkg::YEAR_MIN);
                r_out_month  <= dda_pkg::MONTH_JAN;
                r_out_day    <= dda_pkg::DAY_FIRST;
                r_out_status <= dda_pkg::ST_RANGE;
            end else if (r_year > dda_pkg::YEAR_MAX) begin
                r_out_year   <= dda_pkg::YEAR_W'(dda_pkg::YEAR_MAX);
                r_out_month  <= dda_pkg::MONTH_DEC;
                r_out_day    <= dda_pkg::DAY_LAST;
                r_out_status <= dda_pkg::ST_RANGE;
            end else begin
                r_out_year   <= r_year[dda_pkg::YEAR_W-1:0];
                r_out_month  <= r_month;
                r_out_day    <= r_day[dda_pkg::DAY_W-1:0];
                r_out_status <= dda_pkg::ST_OK;
            end
        end
    end

    assign o_out_year  = r_out_year;
    assign o_out_month = r_out_month;
    assign o_out_day   = r_out_day;
    assign o_status    = r_out_status;

endmodule

FILE: hw/rtl/date_day_offset.sv
// top level of the date day offset block: gregorian date plus signed day count
`timescale 1ns / 1ps

// channel   direction  payload
// s_axis    in         tdata: in_year[13:0] in_month[17:14] in_day[22:18] offset_days[38:23]
// m_axis    out        tdata: out_year[13:0] out_month[17:14] out_day[22:18]; tuser: status
//
// one request at a time; the month stepper moves one month per cycle
// set-up finds year mod 400 by reciprocal multiply and remainder, then checks the date
// a bad starting date skips the walk and goes from the date check straight to the result
// reset (synchronous, active low) clears the state machine and the output valid
// a finished result sits in the output register, so a new request is taken while it waits

module date_day_offset (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // in_year, in_month, in_day, offset_days, one unused pad bit on top
    input  logic [dda_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_year, out_month, out_day, one zero pad bit
    output logic [dda_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // status: ok, bad starting date, year out of range
    output logic [dda_pkg::STAT_W-1:0]          m_axis_tuser
);

    dda_pkg::t_dp_cmd cmd;
    dda_pkg::t_dp_sts sts;

    logic [dda_pkg::YEAR_W-1:0]  out_year;
    logic [dda_pkg::MONTH_W-1:0] out_month;
    logic [dda_pkg::DAY_W-1:0]   out_day;
    dda_pkg::t_status            out_status;

    dda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dda_dp u_dp (
        .i_clk         (i_clk),
        .i_in_year     (s_axis_tdata[13:0]),
        .i_in_month    (s_axis_tdata[17:14]),
        .i_in_day      (s_axis_tdata[22:18]),
        .i_offset_days ($signed(s_axis_tdata[38:23])),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_year    (out_year),
        .o_out_month   (out_month),
        .o_out_day     (out_day),
        .o_status      (out_status)
    );

    // pack result, pad bit on top
    assign m_axis_tdata = {1'b0, out_day, out_month, out_year};
    assign m_axis_tuser = out_status;

endmodule
